FILE: hw/rtl/tef_pkg.sv
// Shared codes, widths and types for the touch event frame assembler.
package tef_pkg;

  // Event kinds
  localparam logic [4:0] KIND_SYN = 5'd0;
  localparam logic [4:0] KIND_KEY = 5'd1;
  localparam logic [4:0] KIND_ABS = 5'd3;

  // Event codes
  localparam logic [9:0] CODE_SYN_REPORT    = 10'h000;
  localparam logic [9:0] CODE_SYN_MT_REPORT = 10'h002;
  localparam logic [9:0] CODE_BTN_TOUCH     = 10'h14a;
  localparam logic [9:0] CODE_ABS_X         = 10'h000;
  localparam logic [9:0] CODE_ABS_Y         = 10'h001;
  localparam logic [9:0] CODE_ABS_PRESSURE  = 10'h018;
  localparam logic [9:0] CODE_MT_X          = 10'h035;
  localparam logic [9:0] CODE_MT_Y          = 10'h036;
  localparam logic [9:0] CODE_MT_MAJOR      = 10'h030;

  // Stream word widths
  localparam int KIND_W     = 5;
  localparam int CODE_W     = 10;
  localparam int VALUE_W    = 32;
  localparam int ID_W       = 4;
  localparam int COORD_W    = 31;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_PAD_W  = OUT_DATA_W - ID_W - 2 * COORD_W;

  // Slot store write command
  typedef struct packed {
    logic set_x;
    logic set_y;
    logic set_p;
    logic clear;
  } slot_wr_t;

endpackage

FILE: hw/rtl/tef_slot_store.sv
// Slot registers (x, y, pressure) with one write port and a qualifying read port.
module tef_slot_store
  import tef_pkg::*;
#(
  parameter int MAX_POINTS = 10,
  parameter int IDX_W      = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  slot_wr_t             wr,
  input  logic [IDX_W-1:0]     wr_idx,
  input  logic [VALUE_W-1:0]   wr_val,
  input  logic [IDX_W-1:0]     rd_idx,
  output logic [COORD_W-1:0]   rd_x,
  output logic [COORD_W-1:0]   rd_y,
  output logic                 rd_hit
);

  logic signed [VALUE_W-1:0] sx [MAX_POINTS];
  logic signed [VALUE_W-1:0] sy [MAX_POINTS];
  logic signed [VALUE_W-1:0] sp [MAX_POINTS];

  // Entries reset to -1; a clear also returns all three to -1
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_POINTS; i++) begin
        sx[i] <= '1;
        sy[i] <= '1;
        sp[i] <= '1;
      end
    end else if (wr.clear) begin
      sx[wr_idx] <= '1;
      sy[wr_idx] <= '1;
      sp[wr_idx] <= '1;
    end else begin
      if (wr.set_x) sx[wr_idx] <= wr_val;
      if (wr.set_y) sy[wr_idx] <= wr_val;
      if (wr.set_p) sp[wr_idx] <= wr_val;
    end
  end

  // Shared compare: a slot reports when pressure, x and y are all positive
  always_comb begin
    rd_x   = sx[rd_idx][COORD_W-1:0];
    rd_y   = sy[rd_idx][COORD_W-1:0];
    rd_hit = (sp[rd_idx] > 0) && (sx[rd_idx] > 0) && (sy[rd_idx] > 0);
  end

endmodule

FILE: hw/rtl/touch_event_frame_assembler.sv
// Top level of the touch event frame assembler.
// Axis, key and slot-advance events are accepted and ready stays high.
// A frame report drops ready and walks the slots one per cycle through a
// single compare unit, pausing while a hit finds the pending point still
// waiting on a stalled output. One point is held back in a pending
// register so the final point of the frame can be marked with tlast; the
// output register lets a finished point wait while the next event comes in.
module touch_event_frame_assembler
  import tef_pkg::*;
#(
  parameter int MAX_POINTS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // event_code[9:0], event_value[41:10], zero pad
  input  logic [KIND_W-1:0]     s_tuser,  // kind[4:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,  // point_id[3:0], point_x[34:4], point_y[65:35], pad
  output logic                  m_tlast   // last point of the frame
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0]   slot_count;
  logic               touch_down;
  logic [CNT_W-1:0]   scan_idx;
  logic [CNT_W-1:0]   scan_n;
  logic               pend_valid;
  logic [ID_W-1:0]    pend_id;
  logic [COORD_W-1:0] pend_x;
  logic [COORD_W-1:0] pend_y;

  logic [CODE_W-1:0]  code;
  logic [VALUE_W-1:0] value;
  logic               accept, is_abs, is_key, is_syn, is_report, is_mt_report;
  logic               room, single_touch;

  slot_wr_t           wr;
  logic [IDX_W-1:0]   wr_idx;
  logic [VALUE_W-1:0] wr_val;
  logic [COORD_W-1:0] rd_x, rd_y;
  logic               rd_hit;

  logic out_free, scan_end, advance, take, push, push_last;

  // Input decode
  assign code         = s_tdata[CODE_W-1:0];
  assign value        = s_tdata[CODE_W+VALUE_W-1:CODE_W];
  assign s_tready     = (state == ST_IDLE);
  assign accept       = s_tvalid && s_tready;
  assign is_abs       = (s_tuser == KIND_ABS);
  assign is_key       = (s_tuser == KIND_KEY);
  assign is_syn       = (s_tuser == KIND_SYN);
  assign is_report    = is_syn && (code == CODE_SYN_REPORT);
  assign is_mt_report = is_syn && (code == CODE_SYN_MT_REPORT);
  assign room         = (slot_count < CNT_MAX);
  assign single_touch = (slot_count == '0) && touch_down;

  // Scan control
  assign out_free  = !m_tvalid || m_tready;
  assign scan_end  = (scan_idx == scan_n);
  assign advance   = (state == ST_SCAN) && !scan_end && (!rd_hit || !pend_valid || out_free);
  assign take      = advance && rd_hit;
  assign push_last = scan_end;
  assign push      = (take && pend_valid) ||
                     ((state == ST_SCAN) && scan_end && pend_valid && out_free);

  // Slot store write command
  always_comb begin
    wr     = '0;
    wr_idx = slot_count[IDX_W-1:0];
    wr_val = value;
    if (state == ST_SCAN) begin
      wr.clear = take;
      wr_idx   = scan_idx[IDX_W-1:0];
    end else if (accept && is_abs && room) begin
      case (code)
        CODE_ABS_X, CODE_MT_X:            wr.set_x = 1'b1;
        CODE_ABS_Y, CODE_MT_Y:            wr.set_y = 1'b1;
        CODE_ABS_PRESSURE, CODE_MT_MAJOR: wr.set_p = 1'b1;
        default:                          wr = '0;
      endcase
    end else if (accept && is_report && single_touch) begin
      wr.set_p = 1'b1;
      wr_idx   = '0;
      wr_val   = '0;
    end
  end

  tef_slot_store #(
    .MAX_POINTS (MAX_POINTS),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .wr_idx (wr_idx),
    .wr_val (wr_val),
    .rd_idx (scan_idx[IDX_W-1:0]),
    .rd_x   (rd_x),
    .rd_y   (rd_y),
    .rd_hit (rd_hit)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && is_report) state_next = ST_SCAN;
      ST_SCAN: if (scan_end && (!pend_valid || out_free)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_count <= '0;
      touch_down <= 1'b0;
      scan_idx   <= '0;
      scan_n     <= '0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (is_key && (code == CODE_BTN_TOUCH)) touch_down <= (value != '0);
        if (is_mt_report && room) slot_count <= slot_count + 1'b1;
        if (is_report) begin
          slot_count <= '0;
          scan_idx   <= '0;
          scan_n     <= single_touch ? CNT_W'(1) : slot_count;
        end
      end
      if (advance) scan_idx <= scan_idx + 1'b1;
      if (take) pend_valid <= 1'b1;
      else if (push) pend_valid <= 1'b0;
    end
  end

  // Pending point payload
  always_ff @(posedge clk) begin
    if (take) begin
      pend_id <= ID_W'(scan_idx);
      pend_x  <= rd_x;
      pend_y  <= rd_y;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      m_tdata <= {{OUT_PAD_W{1'b0}}, pend_y, pend_x, pend_id};
      m_tlast <= push_last;
    end
  end

endmodule

FILE: hw/rtl/tef_checker.sv
// Port-level checks for the touch event frame assembler, bound to the top level.
module tef_checker
  import tef_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [IN_DATA_W-1:0]  s_tdata,
  input logic [KIND_W-1:0]     s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tlast
);

  logic in_acc, in_report;

  assign in_acc    = s_tvalid && s_tready;
  assign in_report = (s_tuser == KIND_SYN) && (s_tdata[CODE_W-1:0] == CODE_SYN_REPORT);

  // A stalled output word stays valid and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word dropped or changed while stalled");

  // A frame report always starts a slot walk
  a_report_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_report |=> !s_tready)
    else $error("input still ready after a frame report");

  // Any other event leaves the input ready
  a_event_fast: assert property (@(posedge clk) disable iff (rst)
    in_acc && !in_report |=> s_tready)
    else $error("input not ready after a plain event");

  // Once idle, only the closing point of a frame may still be waiting
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    s_tready && m_tvalid |-> m_tlast)
    else $error("unfinished frame left waiting while idle");

endmodule

bind touch_event_frame_assembler tef_checker u_tef_checker (.*);

FILE: verif/tb_top.sv
// Self-checking testbench for the touch event frame assembler.
module tb_top;
  import tef_pkg::*;

  localparam int MAX_P   = 10;
  localparam int ITEMS   = 260;
  localparam int LIMIT   = 200000;
  localparam int SETTLE  = 2 * MAX_P + 10;

  // codes the block must ignore
  localparam logic [4:0] KIND_REL       = 5'd2;
  localparam logic [4:0] KIND_SPARE     = 5'd31;
  localparam logic [9:0] CODE_FULL      = 10'h3ff;
  localparam logic [9:0] CODE_KEY_OTHER = 10'h14b;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } point_t;

  // Tracks slot state and queues the points each frame report must produce
  class point_scoreboard;
    int     slot_x[MAX_P];
    int     slot_y[MAX_P];
    int     slot_p[MAX_P];
    int     closed;
    bit     pressed;
    point_t pending[$];
    int     errors;
    int     frames;
    int     points_checked;

    function new();
      for (int i = 0; i < MAX_P; i++) begin
        slot_x[i] = -1;
        slot_y[i] = -1;
        slot_p[i] = -1;
      end
      closed = 0;
      pressed = 0;
      errors = 0;
      frames = 0;
      points_checked = 0;
    endfunction

    function void note_event(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] code, int value);
      int     first;
      point_t pt;
      first = pending.size();
      case (kind)
        KIND_ABS: begin
          if (closed < MAX_P) begin
            if (code == CODE_ABS_X || code == CODE_MT_X)
              slot_x[closed] = value;
            else if (code == CODE_ABS_Y || code == CODE_MT_Y)
              slot_y[closed] = value;
            else if (code == CODE_ABS_PRESSURE || code == CODE_MT_MAJOR)
              slot_p[closed] = value;
          end
        end
        KIND_KEY: begin
          if (code == CODE_BTN_TOUCH)
            pressed = (value != 0);
        end
        KIND_SYN: begin
          if (code == CODE_SYN_MT_REPORT) begin
            if (closed < MAX_P)
              closed++;
          end else if (code == CODE_SYN_REPORT) begin
            frames++;
            // single-touch: empty frame while pressed claims slot 0, unreported
            if (closed == 0 && pressed) begin
              slot_p[0] = 0;
              closed = 1;
            end
            for (int i = 0; i < closed; i++) begin
              if (slot_p[i] > 0 && slot_x[i] > 0 && slot_y[i] > 0) begin
                pt.id   = i[ID_W-1:0];
                pt.x    = slot_x[i][COORD_W-1:0];
                pt.y    = slot_y[i][COORD_W-1:0];
                pt.last = 1'b0;
                pending.push_back(pt);
                slot_x[i] = -1;
                slot_y[i] = -1;
                slot_p[i] = -1;
              end
            end
            if (pending.size() > first)
              pending[pending.size()-1].last = 1'b1;
            closed = 0;
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string what, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_point(logic [OUT_DATA_W-1:0] word, logic tlast);
      point_t want;
      points_checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected point: expected none, actual id %0d x 0x%0h y 0x%0h",
                 $time, word[ID_W-1:0], word[ID_W +: COORD_W],
                 word[ID_W+COORD_W +: COORD_W]);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("point_id", want.id, word[ID_W-1:0]);
      compare_field("point_x", want.x, word[ID_W +: COORD_W]);
      compare_field("point_y", want.y, word[ID_W+COORD_W +: COORD_W]);
      compare_field("last", want.last, tlast);
    endfunction
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [KIND_W-1:0]     s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  point_scoreboard sb = new();
  bit  steady = 1'b0;
  int  words_sent = 0;

  touch_event_frame_assembler #(.MAX_POINTS(MAX_P)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Output side: random stall bursts unless in a steady stretch
  initial begin
    forever begin
      if (steady) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // Point monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_point(m_tdata, m_tlast);
  end

  // Watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d points outstanding", cycles, sb.pending.size());
    $display("TB_ERROR");
    $finish;
  end

  // One event word; called just after a rising edge, returns after acceptance
  task automatic send_event(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] code, int value);
    if (!steady && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{(IN_DATA_W-CODE_W-VALUE_W){1'b0}}, value, code};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_event(kind, code, value);
    words_sent++;
  endtask

  function automatic int rand_value();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: begin
        case ($urandom_range(0, 2))
          0: return 0;
          1: return -1;
          default: return int'($urandom | 32'h8000_0000);
        endcase
      end
      1: return int'(32'h7fff_ffff);
      2, 3, 4: return int'($urandom_range(1, 4095));
      default: return int'($urandom_range(1, 32'h7fff_ffff));
    endcase
  endfunction

  task automatic send_noise();
    logic [KIND_W-1:0] kind;
    case ($urandom_range(0, 3))
      0: kind = KIND_SYN;
      1: kind = KIND_KEY;
      2: kind = KIND_ABS;
      default: kind = KIND_W'($urandom_range(0, 31));
    endcase
    send_event(kind, CODE_W'($urandom_range(0, 1023)), int'($urandom));
  endtask

  // A well-formed frame with random content, sometimes broken or overfull
  task automatic random_frame();
    int contacts;
    int r;
    int rot;
    r = $urandom_range(0, 19);
    if (r < 2)
      contacts = 0;
    else if (r < 12)
      contacts = $urandom_range(1, 3);
    else if (r < 17)
      contacts = $urandom_range(4, MAX_P - 1);
    else if (r < 19)
      contacts = MAX_P;
    else
      contacts = $urandom_range(MAX_P + 1, MAX_P + 2);

    if ($urandom_range(0, 3) == 0)
      send_event(KIND_KEY, CODE_BTN_TOUCH, $urandom_range(0, 1) ? int'($urandom) : 0);
    for (int c = 0; c < contacts; c++) begin
      rot = $urandom_range(0, 2);
      for (int f = 0; f < 3; f++) begin
        if ($urandom_range(0, 9) == 0)
          send_noise();
        if ($urandom_range(0, 19) == 0)
          continue;
        case ((f + rot) % 3)
          0: send_event(KIND_ABS, $urandom_range(0, 1) ? CODE_ABS_X : CODE_MT_X, rand_value());
          1: send_event(KIND_ABS, $urandom_range(0, 1) ? CODE_ABS_Y : CODE_MT_Y, rand_value());
          default: send_event(KIND_ABS, $urandom_range(0, 1) ? CODE_ABS_PRESSURE : CODE_MT_MAJOR,
                              rand_value());
        endcase
      end
      // occasionally leave the last contact open
      if (!(c == contacts - 1 && $urandom_range(0, 9) == 0))
        send_event(KIND_SYN, CODE_SYN_MT_REPORT, 0);
    end
    if ($urandom_range(0, 19) != 0)
      send_event(KIND_SYN, CODE_SYN_REPORT, 0);
  endtask

  // Main sequence
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // plain single contact
    send_event(KIND_ABS, CODE_ABS_X, 100);
    send_event(KIND_ABS, CODE_ABS_Y, 200);
    send_event(KIND_ABS, CODE_ABS_PRESSURE, 50);
    send_event(KIND_SYN, CODE_SYN_MT_REPORT, 0);
    send_event(KIND_SYN, CODE_SYN_REPORT, 0);
    // extremes: max coords, zero pressure, most negative x, then a good slot
    send_event(KIND_ABS, CODE_MT_X, int'(32'h7fff_ffff));
    send_event(KIND_ABS, CODE_MT_Y, 1);
    send_event(KIND_ABS, CODE_MT_MAJOR, int'(32'h7fff_ffff));
    send_event(KIND_SYN, CODE_SYN_MT_REPORT, 0);
    send_event(KIND_ABS, CODE_MT_X, 1);
    send_event(KIND_ABS, CODE_MT_Y, int'(32'h7fff_ffff));
    send_event(KIND_ABS, CODE_MT_MAJOR, 0);
    send_event(KIND_SYN, CODE_SYN_MT_REPORT, 0);
    send_event(KIND_ABS, CODE_ABS_X, int'(32'h8000_0000));
    send_event(KIND_SYN, CODE_SYN_MT_REPORT, 0);
    send_event(KIND_ABS, CODE_ABS_PRESSURE, 9);
    send_event(KIND_ABS, CODE_MT_X, 7);
    send_event(KIND_ABS, CODE_MT_Y, 8);
    send_event(KIND_SYN, CODE_SYN_MT_REPORT, 0);
    send_event(KIND_SYN, CODE_SYN_REPORT, 0);
    // single-touch rule, then release
    send_event(KIND_KEY, CODE_BTN_TOUCH, -1);
    send_event(KIND_SYN, CODE_SYN_REPORT, 0);
    send_event(KIND_KEY, CODE_BTN_TOUCH, 0);
    // events that must be ignored
    send_event(KIND_KEY, CODE_KEY_OTHER, 1);
    send_event(KIND_SYN, CODE_FULL, 0);
    send_event(KIND_ABS, CODE_FULL, 5);
    send_event(KIND_REL, CODE_MT_X, 3);
    send_event(KIND_SPARE, CODE_FULL, -1);

    // random frames; a steady stretch mid-run and at the end
    while (words_sent < ITEMS) begin
      steady = (words_sent >= 100 && words_sent < 140) || (words_sent >= ITEMS - 50);
      random_frame();
    end
    steady = 1'b1;
    s_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d event words over %0d frame reports; checked %0d points.",
             words_sent, sb.frames, sb.points_checked);
    $display("Covered overfull frames, single-touch frames, open slots and ignored events.");
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/tef_pkg.sv
hw/rtl/tef_slot_store.sv
hw/rtl/touch_event_frame_assembler.sv
hw/rtl/tef_checker.sv
verif/tb_top.sv
